>>> rtl/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// wsfp_pkg: shared types and constants of the WebSocket frame parser
// Parser phases, result kinds, length codes and the result record that
// travels from the decoder to the output register.
// ----------------------------------------------------------------------------
package wsfp_pkg;

    localparam int unsigned LEN_W = 64;
    localparam int unsigned MAXP_W = 63;

    localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RESET = 63'd1048576;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // extended length bytes still to read, minus one
    localparam logic [2:0] EXT_CNT_16 = 3'd1;
    localparam logic [2:0] EXT_CNT_64 = 3'd7;

    localparam logic [1:0] MASK_CNT_LAST = 2'd3;

    typedef enum logic [2:0] {
        PH_B0   = 3'd0,
        PH_B1   = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_PAY  = 3'd4,
        PH_HALT = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_TOO_BIG = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic             fin;
        logic [2:0]       rsv_bits;
        logic [3:0]       opcode;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       data_byte;
        logic             last_of_frame;
    } result_t;

endpackage

>>> rtl/websocket_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_parser_unit: WebSocket receive-side frame parser
// Decodes the frame header, unmasks payload bytes and flags oversize frames.
// ----------------------------------------------------------------------------
// One stream byte is taken per cycle; its result, if any, appears on the
// master side in the next cycle from a single output register. s_tready is
// high whenever that register is empty or being drained, so bytes pass in at
// full rate while the master side keeps up; a held result stalls every byte,
// also those that make no result (first header byte, extended length, mask
// key) and those that follow an error. A header item (tuser 0) follows the
// last header byte, payload items (tuser 1) follow one per payload byte, and
// a length above max_payload gives an error item (tuser 2), after which every
// byte is dropped until reset. max_payload may be written only while idle.
module websocket_frame_parser_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // [0] fin, [3:1] rsv_bits, [7:4] opcode,
                                    // [71:8] payload_length, [79:72] data_byte
    output logic [1:0]   m_tuser,   // [1:0] kind
    output logic         m_tlast,   // last_of_frame
    input  logic         cfg_we,
    input  logic [62:0]  cfg_wdata  // max_payload
);
    import wsfp_pkg::*;

    logic    accept;
    logic    res_valid;
    logic    slot_free;
    result_t res;
    result_t out_res;

    assign s_tready = slot_free;
    assign accept   = s_tvalid && slot_free;

    wsfp_decoder u_decoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (accept),
        .in_byte    (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    wsfp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_data (res),
        .slot_free (slot_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.data_byte, out_res.payload_length, out_res.opcode,
                      out_res.rsv_bits, out_res.fin};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last_of_frame;

endmodule

>>> rtl/wsfp_decoder.sv
// ----------------------------------------------------------------------------
// wsfp_decoder: frame header and payload decoder
// Holds the parse state, takes one stream byte per accepted request and
// produces at most one result record for it in the same cycle.
// ----------------------------------------------------------------------------
module wsfp_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_valid,
    input  logic [7:0]                    in_byte,
    input  logic                          cfg_we,
    input  logic [wsfp_pkg::MAXP_W-1:0]   cfg_wdata,
    output logic                          res_valid,
    output wsfp_pkg::result_t             res
);
    import wsfp_pkg::*;

    phase_t             phase_reg, phase_next;
    logic               fin_reg, fin_next;
    logic [2:0]         rsv_reg, rsv_next;
    logic [3:0]         opcode_reg, opcode_next;
    logic               mask_on_reg, mask_on_next;
    logic [LEN_W-1:0]   length_reg, length_next;
    logic [2:0]         ext_cnt_reg, ext_cnt_next;
    logic [31:0]        mask_word_reg, mask_word_next;
    logic [1:0]         mask_cnt_reg, mask_cnt_next;
    logic [LEN_W-1:0]   remaining_reg, remaining_next;
    logic [1:0]         pidx_reg, pidx_next;
    logic [MAXP_W-1:0]  max_payload_reg;

    logic [6:0]         len_code;
    logic [LEN_W-1:0]   len_new;
    logic [LEN_W-1:0]   len_cur;
    logic               too_big;
    logic               mask_cur;
    logic               ext_done;
    logic               last_pay;
    logic [7:0]         key;

    // length as it stands once this byte is taken in
    always_comb begin
        len_code = in_byte[6:0];
        if (phase_reg == PH_B1) begin
            len_new = {{(LEN_W-7){1'b0}}, len_code};
        end else begin
            len_new = {length_reg[LEN_W-9:0], in_byte};
        end
        len_cur  = ((phase_reg == PH_B1) || (phase_reg == PH_EXT)) ? len_new : length_reg;
        too_big  = len_new > {1'b0, max_payload_reg};
        mask_cur = (phase_reg == PH_B1) ? in_byte[7] : mask_on_reg;
        ext_done = (phase_reg == PH_B1) ? !(len_code inside {LEN_CODE_16, LEN_CODE_64})
                                        : (ext_cnt_reg == 3'd0);
        last_pay = (remaining_reg == {{(LEN_W-1){1'b0}}, 1'b1});
        case (pidx_reg)
            2'd0:    key = mask_word_reg[31:24];
            2'd1:    key = mask_word_reg[23:16];
            2'd2:    key = mask_word_reg[15:8];
            default: key = mask_word_reg[7:0];
        endcase
        if (!mask_on_reg) begin
            key = 8'd0;
        end
    end

    // next state
    always_comb begin
        phase_next     = phase_reg;
        fin_next       = fin_reg;
        rsv_next       = rsv_reg;
        opcode_next    = opcode_reg;
        mask_on_next   = mask_on_reg;
        length_next    = length_reg;
        ext_cnt_next   = ext_cnt_reg;
        mask_word_next = mask_word_reg;
        mask_cnt_next  = mask_cnt_reg;
        remaining_next = remaining_reg;
        pidx_next      = pidx_reg;
        if (byte_valid) begin
            case (phase_reg)
                PH_B0: begin
                    fin_next    = in_byte[7];
                    rsv_next    = in_byte[6:4];
                    opcode_next = in_byte[3:0];
                    phase_next  = PH_B1;
                end
                PH_B1, PH_EXT: begin
                    if (phase_reg == PH_B1) begin
                        mask_on_next = in_byte[7];
                    end
                    if (!ext_done) begin
                        if (phase_reg == PH_B1) begin
                            length_next  = '0;
                            ext_cnt_next = (len_code == LEN_CODE_16) ? EXT_CNT_16
                                                                     : EXT_CNT_64;
                            phase_next   = PH_EXT;
                        end else begin
                            length_next  = len_new;
                            ext_cnt_next = ext_cnt_reg - 3'd1;
                        end
                    end else begin
                        length_next = len_new;
                        if (too_big) begin
                            phase_next = PH_HALT;
                        end else if (mask_cur) begin
                            mask_word_next = '0;
                            mask_cnt_next  = '0;
                            phase_next     = PH_MASK;
                        end else begin
                            remaining_next = len_new;
                            pidx_next      = '0;
                            phase_next     = (len_new == '0) ? PH_B0 : PH_PAY;
                        end
                    end
                end
                PH_MASK: begin
                    mask_word_next = {mask_word_reg[23:0], in_byte};
                    if (mask_cnt_reg == MASK_CNT_LAST) begin
                        mask_cnt_next  = '0;
                        remaining_next = length_reg;
                        pidx_next      = '0;
                        phase_next     = (length_reg == '0) ? PH_B0 : PH_PAY;
                    end else begin
                        mask_cnt_next = mask_cnt_reg + 2'd1;
                    end
                end
                PH_PAY: begin
                    pidx_next      = pidx_reg + 2'd1;
                    remaining_next = remaining_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                    if (last_pay) begin
                        phase_next = PH_B0;
                    end
                end
                default: begin
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    // result record
    always_comb begin
        res_valid          = 1'b0;
        res.kind           = KIND_HEADER;
        res.fin            = fin_reg;
        res.rsv_bits       = rsv_reg;
        res.opcode         = opcode_reg;
        res.payload_length = len_cur;
        res.data_byte      = 8'd0;
        res.last_of_frame  = 1'b0;
        if (byte_valid) begin
            case (phase_reg)
                PH_B1, PH_EXT: begin
                    if (ext_done) begin
                        if (too_big) begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_TOO_BIG;
                            res.last_of_frame = 1'b1;
                        end else if (!mask_cur) begin
                            res_valid         = 1'b1;
                            res.last_of_frame = (len_new == '0);
                        end
                    end
                end
                PH_MASK: begin
                    if (mask_cnt_reg == MASK_CNT_LAST) begin
                        res_valid         = 1'b1;
                        res.last_of_frame = (length_reg == '0);
                    end
                end
                PH_PAY: begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_PAYLOAD;
                    res.data_byte     = in_byte ^ key;
                    res.last_of_frame = last_pay;
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_B0;
            fin_reg         <= 1'b0;
            rsv_reg         <= '0;
            opcode_reg      <= '0;
            mask_on_reg     <= 1'b0;
            length_reg      <= '0;
            ext_cnt_reg     <= '0;
            mask_word_reg   <= '0;
            mask_cnt_reg    <= '0;
            remaining_reg   <= '0;
            pidx_reg        <= '0;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else begin
            phase_reg     <= phase_next;
            fin_reg       <= fin_next;
            rsv_reg       <= rsv_next;
            opcode_reg    <= opcode_next;
            mask_on_reg   <= mask_on_next;
            length_reg    <= length_next;
            ext_cnt_reg   <= ext_cnt_next;
            mask_word_reg <= mask_word_next;
            mask_cnt_reg  <= mask_cnt_next;
            remaining_reg <= remaining_next;
            pidx_reg      <= pidx_next;
            if (cfg_we) begin
                max_payload_reg <= cfg_wdata;
            end
        end
    end

endmodule

>>> rtl/wsfp_out_reg.sv
// ----------------------------------------------------------------------------
// wsfp_out_reg: result output register
// Holds one result record toward the master side; frees itself in the
// same cycle the held request is taken, so a new one can load behind it.
// ----------------------------------------------------------------------------
module wsfp_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  wsfp_pkg::result_t  load_data,
    output logic               slot_free,
    output logic               out_valid,
    input  logic               out_ready,
    output wsfp_pkg::result_t  out_data
);
    import wsfp_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule
